### hw/rtl/ffba_pkg.sv
`default_nettype none
package ffba_pkg;

  localparam int HEAP_UNITS = 4096;
  localparam int WORD_BITS  = 16;
  localparam int MAP_ROWS   = HEAP_UNITS / WORD_BITS;
  localparam int UNIT_W     = $clog2(HEAP_UNITS);
  localparam int BOUND_W    = UNIT_W + 1;
  localparam int ROW_W      = $clog2(MAP_ROWS);
  localparam int BIT_W      = $clog2(WORD_BITS);

  // item field widths
  localparam int CMD_W   = 2;
  localparam int SIZE_W  = 13;
  localparam int START_W = 12;

  localparam logic [CMD_W-1:0] CMD_ALLOC    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE_ALL = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [ROW_W-1:0]     row_t;
  typedef logic [BOUND_W-1:0]   bound_t;
  typedef logic [SIZE_W-1:0]    size_t;
  typedef logic [START_W-1:0]   start_t;
  typedef logic [BIT_W-1:0]     bit_idx_t;

  localparam bound_t HEAP_BOUND = BOUND_W'(HEAP_UNITS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_WRITE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic  rd_en;
    row_t  rd_row;
    logic  wr_en;
    row_t  wr_row;
    word_t wr_data;
    logic  clr_all;
  } map_req_t;

  typedef struct packed {
    logic     hit;
    bit_idx_t idx;
    size_t    carry;
  } scan_res_t;

  // bits of one map row whose unit lies in [lo, hi)
  function automatic word_t row_mask(row_t row, bound_t lo, bound_t hi);
    word_t  m;
    bound_t u;
    for (int i = 0; i < WORD_BITS; i++) begin
      u    = {1'b0, row, BIT_W'(i)};
      m[i] = (u >= lo) && (u < hi);
    end
    return m;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/ffba_in_if.sv
`default_nettype none
interface ffba_in_if;
  import ffba_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  size_t             req_size;
  bound_t            window_low;
  bound_t            window_high;
  start_t            run_start;

  modport source (output valid, cmd, req_size, window_low, window_high, run_start,
                  input ready);
  modport sink   (input valid, cmd, req_size, window_low, window_high, run_start,
                  output ready);
endinterface
`default_nettype wire

### hw/rtl/ffba_out_if.sv
`default_nettype none
interface ffba_out_if;
  import ffba_pkg::*;

  logic   valid;
  logic   ready;
  logic   status;
  start_t alloc_start;

  modport source (output valid, status, alloc_start, input ready);
  modport sink   (input valid, status, alloc_start, output ready);
endinterface
`default_nettype wire

### hw/rtl/ffba_map_ram.sv
`default_nettype none
module ffba_map_ram (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ffba_pkg::map_req_t req,
  output ffba_pkg::word_t         rd_word
);
  import ffba_pkg::*;

  word_t                map_mem [MAP_ROWS];
  logic [MAP_ROWS-1:0]  row_valid_r;
  word_t                rd_data_r;
  logic                 rd_valid_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      map_mem[req.wr_row] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= map_mem[req.rd_row];
    end
  end

  // a row never written since reset or free-all reads as all free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      rd_valid_r  <= 1'b0;
    end else begin
      if (req.clr_all) begin
        row_valid_r <= '0;
      end else if (req.wr_en) begin
        row_valid_r[req.wr_row] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid_r <= row_valid_r[req.rd_row];
      end
    end
  end

  assign rd_word = rd_valid_r ? rd_data_r : '0;

endmodule
`default_nettype wire

### hw/rtl/ffba_scan_unit.sv
`default_nettype none
module ffba_scan_unit (
  input  wire ffba_pkg::word_t  map_word,
  input  wire ffba_pkg::word_t  elig,
  input  wire ffba_pkg::size_t  carry,
  input  wire ffba_pkg::size_t  size,
  output ffba_pkg::scan_res_t   res
);
  import ffba_pkg::*;

  word_t free_e;
  size_t run_len [WORD_BITS];

  assign free_e = ~map_word & elig;

  // free run length ending at each bit, continuing the run from earlier rows
  always_comb begin : p_run
    logic     blocked;
    bit_idx_t last_blk;
    for (int i = 0; i < WORD_BITS; i++) begin
      blocked  = 1'b0;
      last_blk = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
        if (j <= i && !free_e[j]) begin
          blocked  = 1'b1;
          last_blk = BIT_W'(j);
        end
      end
      run_len[i] = blocked ? (SIZE_W'(i) - SIZE_W'(last_blk))
                           : (carry + SIZE_W'(i + 1));
    end
  end

  // lowest bit where the run reaches the requested size
  always_comb begin
    res.hit   = 1'b0;
    res.idx   = '0;
    res.carry = run_len[WORD_BITS-1];
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (run_len[i] >= size) begin
        res.hit = 1'b1;
        res.idx = BIT_W'(i);
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/first_fit_bitmap_allocator.sv
`default_nettype none
// Steps: allocate passes S_START, S_SCAN over the rows scanned, S_WRITE over the
//   rows claimed (16 units per row, up to 256 rows each way) and S_DONE; free skips
//   S_SCAN; free-all and unused codes pass S_START and S_DONE. Throughput: one item
//   at a time; the map RAM port and the row scan unit set the pace at one 16-unit
//   row per cycle. A waiting result does not block intake. Reset: synchronous;
//   per-row valid bits clear, so the map reads all free right away with no clearing pass.
module first_fit_bitmap_allocator (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ffba_in_if.sink    in_ch,
  ffba_out_if.source out_ch
);
  import ffba_pkg::*;

  // sequencer state and latched command
  state_t            state_r,   state_nxt;
  logic [CMD_W-1:0]  cmd_r,     cmd_nxt;
  size_t             size_r,    size_nxt;
  bound_t            lo_r,      lo_nxt;     // window low, or first unit of a write range
  bound_t            hi_r,      hi_nxt;     // raw/clipped bound, or write range end
  start_t            rstart_r,  rstart_nxt;
  row_t              row_r,     row_nxt;
  size_t             carry_r,   carry_nxt;  // free run carried in from earlier rows
  logic              set_r,     set_nxt;    // 1 claims units, 0 frees them

  // pending result and output register
  logic              res_status_r, res_status_nxt;
  start_t            res_start_r,  res_start_nxt;
  logic              out_valid_r,  out_valid_nxt;
  logic              out_status_r;
  start_t            out_start_r;
  logic              load_out;

  map_req_t          map_req;
  word_t             rd_word;
  word_t             mask_c;
  scan_res_t         scan_res;

  bound_t            bound_c;
  bound_t            hi_m1_c;
  row_t              last_row_c;
  logic [BOUND_W:0]  free_end_c;
  bound_t            pos_end_c;
  bound_t            first_c;
  logic              in_accept;

  ffba_map_ram u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (map_req),
    .rd_word (rd_word)
  );

  ffba_scan_unit u_scan (
    .map_word (rd_word),
    .elig     (mask_c),
    .carry    (carry_r),
    .size     (size_r),
    .res      (scan_res)
  );

  assign in_accept  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  // one mask serves both the scan window and the claim/free range
  assign mask_c     = row_mask(row_r, lo_r, hi_r);
  assign hi_m1_c    = hi_r - bound_t'(1);
  assign last_row_c = hi_m1_c[UNIT_W-1:BIT_W];

  // windows past the heap are clipped to its end
  assign bound_c    = (hi_r > HEAP_BOUND) ? HEAP_BOUND : hi_r;
  assign free_end_c = {2'b00, rstart_r} + {1'b0, size_r};

  // run found: its last unit is {row, idx}
  assign pos_end_c  = {1'b0, row_r, scan_res.idx} + bound_t'(1);
  assign first_c    = pos_end_c - size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    size_r       <= size_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    rstart_r     <= rstart_nxt;
    row_r        <= row_nxt;
    carry_r      <= carry_nxt;
    set_r        <= set_nxt;
    res_status_r <= res_status_nxt;
    res_start_r  <= res_start_nxt;
    if (load_out) begin
      out_status_r <= res_status_r;
      out_start_r  <= res_start_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    size_nxt       = size_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    rstart_nxt     = rstart_r;
    row_nxt        = row_r;
    carry_nxt      = carry_r;
    set_nxt        = set_r;
    res_status_nxt = res_status_r;
    res_start_nxt  = res_start_r;
    load_out       = 1'b0;
    map_req        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          cmd_nxt    = in_ch.cmd;
          size_nxt   = in_ch.req_size;
          lo_nxt     = in_ch.window_low;
          hi_nxt     = in_ch.window_high;
          rstart_nxt = in_ch.run_start;
          state_nxt  = S_START;
        end
      end

      S_START: begin
        res_status_nxt = STATUS_OK;
        res_start_nxt  = '0;
        state_nxt      = S_DONE;
        unique case (cmd_r)
          CMD_ALLOC: begin
            if (size_r == '0 || lo_r >= bound_c) begin
              res_status_nxt = STATUS_FAIL;
            end else begin
              hi_nxt         = bound_c;
              carry_nxt      = '0;
              row_nxt        = lo_r[UNIT_W-1:BIT_W];
              map_req.rd_en  = 1'b1;
              map_req.rd_row = lo_r[UNIT_W-1:BIT_W];
              state_nxt      = S_SCAN;
            end
          end
          CMD_FREE: begin
            // units past the heap end are dropped from the run
            lo_nxt  = {1'b0, rstart_r};
            hi_nxt  = (free_end_c > {1'b0, HEAP_BOUND}) ? HEAP_BOUND
                                                        : free_end_c[BOUND_W-1:0];
            set_nxt = 1'b0;
            if (size_r != '0) begin
              row_nxt        = rstart_r[UNIT_W-1:BIT_W];
              map_req.rd_en  = 1'b1;
              map_req.rd_row = rstart_r[UNIT_W-1:BIT_W];
              state_nxt      = S_WRITE;
            end
          end
          CMD_FREE_ALL: begin
            map_req.clr_all = 1'b1;
          end
          default: begin
            // unused code: no map change, success result
          end
        endcase
      end

      S_SCAN: begin
        if (scan_res.hit) begin
          lo_nxt         = first_c;
          hi_nxt         = pos_end_c;
          set_nxt        = 1'b1;
          res_status_nxt = STATUS_OK;
          res_start_nxt  = first_c[UNIT_W-1:0];
          row_nxt        = first_c[UNIT_W-1:BIT_W];
          map_req.rd_en  = 1'b1;
          map_req.rd_row = first_c[UNIT_W-1:BIT_W];
          state_nxt      = S_WRITE;
        end else if (row_r == last_row_c) begin
          res_status_nxt = STATUS_FAIL;
          res_start_nxt  = '0;
          state_nxt      = S_DONE;
        end else begin
          carry_nxt      = scan_res.carry;
          row_nxt        = row_r + row_t'(1);
          map_req.rd_en  = 1'b1;
          map_req.rd_row = row_r + row_t'(1);
        end
      end

      S_WRITE: begin
        // read-modify-write, one row per cycle
        map_req.wr_en   = 1'b1;
        map_req.wr_row  = row_r;
        map_req.wr_data = set_r ? (rd_word | mask_c) : (rd_word & ~mask_c);
        if (row_r == last_row_c) begin
          state_nxt = S_DONE;
        end else begin
          row_nxt        = row_r + row_t'(1);
          map_req.rd_en  = 1'b1;
          map_req.rd_row = row_r + row_t'(1);
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.alloc_start = out_start_r;

  // one item in flight: intake closes right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_ch.ready)
    else $error("input taken while an item is in flight");

  // the scan never walks past the row holding the last unit of the window
  a_scan_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (row_r <= last_row_c))
    else $error("scan beyond window");

  // units being claimed must have been free
  a_claim_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE && set_r) |-> ((rd_word & mask_c) == '0))
    else $error("claiming a used unit");

  a_clear_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    map_req.clr_all |-> (cmd_r == CMD_FREE_ALL))
    else $error("map cleared by a command other than free-all");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside completion");

endmodule
`default_nettype wire

### sim/ffba_alloc_monitor.sv
`default_nettype none
module ffba_alloc_monitor (
  input  wire logic clk,
  input  wire logic rst_n,
  ffba_in_if        in_ch,
  ffba_out_if       out_ch,
  output int        mismatches,
  output int        pending,
  output int        grants,
  output int        refusals
);
  import ffba_pkg::*;

  typedef struct packed {
    logic   status;
    start_t alloc_start;
  } reply_t;

  bit [HEAP_UNITS-1:0] used_map;
  reply_t              pending_replies[$];
  int                  bad_count = 0;
  int                  owed_count = 0;
  int                  grant_count = 0;
  int                  refusal_count = 0;

  assign mismatches = bad_count;
  assign pending    = owed_count;
  assign grants     = grant_count;
  assign refusals   = refusal_count;

  task automatic report_mismatch(string msg);
    bad_count++;
    $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  // Updates the occupancy map for one command and returns its reply.
  function automatic reply_t apply_to_map(logic [CMD_W-1:0] cmd, size_t sz, bound_t lo,
                                          bound_t hi, start_t rs);
    reply_t r;
    int     bound;
    int     run;
    int     pos;
    int     first;
    bit     found;
    r.status      = STATUS_OK;
    r.alloc_start = '0;
    case (cmd)
      CMD_ALLOC: begin
        bound = (int'(hi) > HEAP_UNITS) ? HEAP_UNITS : int'(hi);
        run   = 0;
        first = 0;
        found = 1'b0;
        if (sz != '0) begin
          for (pos = int'(lo); pos < bound && !found; pos++) begin
            if (used_map[pos]) begin
              run = 0;
            end else begin
              run++;
              if (run == int'(sz)) begin
                found = 1'b1;
                first = pos + 1 - run;
              end
            end
          end
        end
        if (found) begin
          for (pos = first; pos < first + int'(sz); pos++) used_map[pos] = 1'b1;
          r.alloc_start = start_t'(first);
          grant_count++;
        end else begin
          r.status = STATUS_FAIL;
          refusal_count++;
        end
      end
      CMD_FREE: begin
        for (pos = int'(rs); pos < int'(rs) + int'(sz) && pos < HEAP_UNITS; pos++)
          used_map[pos] = 1'b0;
      end
      CMD_FREE_ALL: begin
        used_map = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // results are checked before new items are predicted, so an early result is never
  // matched against an item accepted on the same edge
  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      used_map = '0;
      pending_replies.delete();
      owed_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_replies.size() == 0) begin
          report_mismatch($sformatf("result with none pending: status %0d start %0d",
                                    out_ch.status, out_ch.alloc_start));
        end else begin
          want = pending_replies.pop_front();
          if (out_ch.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      out_ch.status, want.status));
          if (out_ch.alloc_start !== want.alloc_start)
            report_mismatch($sformatf("alloc_start got %0d want %0d",
                                      out_ch.alloc_start, want.alloc_start));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        want = apply_to_map(in_ch.cmd, in_ch.req_size, in_ch.window_low,
                            in_ch.window_high, in_ch.run_start);
        pending_replies.push_back(want);
      end
      owed_count = pending_replies.size();
    end
  end

endmodule
`default_nettype wire

### sim/first_fit_bitmap_allocator_tb.sv
`default_nettype none
module first_fit_bitmap_allocator_tb;
  import ffba_pkg::*;

  // code three is not decoded by the block; it must come back as a plain success
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int N_RANDOM       = 1630;
  localparam int SQUEEZE_AT     = 300;    // random item at which the long hold-off starts
  localparam int SQUEEZE_CYCLES = 2000;
  // slowest allocate: all 256 rows scanned and 256 rows claimed, plus a long output stall
  localparam int DRAIN_CYCLES   = 600;
  // per item: worst latency, longest input gap and longest output stall, several times over
  localparam int CYCLE_LIMIT    = (N_RANDOM + 50) * 2000 + SQUEEZE_CYCLES;

  logic clk;
  logic rst_n;

  ffba_in_if  in_ch();
  ffba_out_if out_ch();

  int mismatches;
  int pending;
  int grants;
  int refusals;
  int sent = 0;
  int cycles = 0;
  bit calm = 1'b0;         // set during stretches with no idling on either side
  bit squeeze_req = 1'b0;
  bit squeeze_done = 1'b0;

  first_fit_bitmap_allocator i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ffba_alloc_monitor i_monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .mismatches (mismatches),
    .pending    (pending),
    .grants     (grants),
    .refusals   (refusals)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("Mismatches found");
      $finish;
    end
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (calm || r < 50) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(50, 10);
  endfunction

  // Offers one item, optionally after a gap, and returns once it is accepted.
  // Valid stays high into the next item when no gap is drawn.
  task automatic push_item(logic [CMD_W-1:0] cmd, size_t sz, bound_t lo, bound_t hi,
                           start_t rs);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= cmd;
    in_ch.req_size    <= sz;
    in_ch.window_low  <= lo;
    in_ch.window_high <= hi;
    in_ch.run_start   <= rs;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sent++;
  endtask

  // Result side: random ready pattern, plus one long hold-off so the block backs up
  // and stalls intake while the sender keeps offering.
  initial begin
    int run;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (squeeze_req && !squeeze_done) begin
        out_ch.ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        squeeze_done = 1'b1;
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(40, 1)) @(posedge clk);
      run = idle_len();
      if (run > 0) begin
        out_ch.ready <= 1'b0;
        repeat (run) @(posedge clk);
      end
    end
  end

  initial begin
    int r;
    int w;
    int sz;
    int lo;
    int hi;
    int rs;

    in_ch.valid       <= 1'b0;
    in_ch.cmd         <= CMD_ALLOC;
    in_ch.req_size    <= '0;
    in_ch.window_low  <= '0;
    in_ch.window_high <= '0;
    in_ch.run_start   <= '0;
    rst_n             <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed ----
    push_item(CMD_ALLOC, 0, 0, 4096, 0);         // zero size fails
    push_item(CMD_ALLOC, 1, 0, 4096, 0);         // -> 0
    push_item(CMD_ALLOC, 16, 0, 4096, 0);        // -> 1
    push_item(CMD_ALLOC, 4096, 0, 4096, 0);      // no fit, heap partly used
    push_item(CMD_FREE_ALL, 0, 0, 0, 0);
    push_item(CMD_ALLOC, 4096, 0, 4096, 0);      // whole heap, run ends at bound
    push_item(CMD_ALLOC, 1, 0, 8191, 0);         // heap full
    push_item(CMD_FREE, 100, 0, 0, 4090);        // run sticks out past the heap
    push_item(CMD_ALLOC, 6, 4090, 8191, 0);      // window clipped to heap -> 4090
    push_item(CMD_FREE, 8191, 0, 0, 0);          // largest free clears all
    push_item(CMD_ALLOC, 10, 100, 110, 0);       // run ends exactly at upper -> 100
    push_item(CMD_ALLOC, 10, 120, 129, 0);       // window smaller than size
    push_item(CMD_ALLOC, 1, 4096, 4096, 0);      // low at the clipped bound
    push_item(CMD_ALLOC, 1, 5000, 8191, 0);      // low past the heap
    push_item(CMD_ALLOC, 5, 3000, 2000, 0);      // inverted window
    push_item(CMD_UNUSED, 8191, 8191, 8191, 4095);
    push_item(CMD_ALLOC, 1, 4095, 4096, 0);      // last unit -> 4095
    push_item(CMD_FREE, 1, 0, 0, 4095);
    push_item(CMD_FREE, 50, 0, 0, 4000);         // units already free
    push_item(CMD_ALLOC, 4096, 0, 4096, 0);      // blocked by 100..109
    push_item(CMD_ALLOC, 8191, 0, 8191, 0);      // larger than the heap
    push_item(CMD_FREE, 0, 0, 0, 100);           // empty run, nothing cleared
    push_item(CMD_ALLOC, 4, 98, 4096, 0);        // gap at 98 too short -> 110
    push_item(CMD_FREE_ALL, 8191, 8191, 8191, 4095);

    // ---- random ----
    // Mostly well-formed allocations with small sizes over the full heap, against
    // frees of short runs, so the map fills and fragments; free-all now and then
    // starts over. The rest is odd windows, zero sizes and the unused code.
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 150 == 0) calm = ($urandom_range(3) == 0);
      if (i == SQUEEZE_AT) squeeze_req = 1'b1;
      // fields the command ignores still carry random bits
      sz = $urandom_range(8191);
      lo = $urandom_range(8191);
      hi = $urandom_range(8191);
      rs = $urandom_range(4095);
      r  = $urandom_range(99);
      if (r < 55) begin
        w = $urandom_range(99);
        if (w < 80)      sz = $urandom_range(32, 1);
        else if (w < 95) sz = $urandom_range(256, 33);
        else if (w < 99) sz = $urandom_range(1024, 257);
        else             sz = $urandom_range(4096, 1025);
        w = $urandom_range(99);
        if (w < 75) begin
          lo = 0;
          hi = HEAP_UNITS;
        end else if (w < 92) begin
          lo = $urandom_range(HEAP_UNITS - 1);
          hi = lo + $urandom_range(1024, 1);
        end
        push_item(CMD_ALLOC, size_t'(sz), bound_t'(lo), bound_t'(hi), start_t'(rs));
      end else if (r < 88) begin
        if ($urandom_range(9) != 0) sz = $urandom_range(64, 1);
        push_item(CMD_FREE, size_t'(sz), bound_t'(lo), bound_t'(hi), start_t'(rs));
      end else if (r < 90) begin
        push_item(CMD_FREE_ALL, size_t'(sz), bound_t'(lo), bound_t'(hi), start_t'(rs));
      end else if (r < 95) begin
        push_item(CMD_UNUSED, size_t'(sz), bound_t'(lo), bound_t'(hi), start_t'(rs));
      end else begin
        if ($urandom_range(1) == 0) sz = 0;
        push_item(CMD_ALLOC, size_t'(sz), bound_t'(lo), bound_t'(hi), start_t'(rs));
      end
    end
    in_ch.valid <= 1'b0;

    // drain: let the monitor see the last item, then wait out outstanding results
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d commands: %0d allocations granted, %0d refused,", sent, grants,
             refusals);
    $display("with random idling on both sides and one long result hold-off.");
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

### first_fit_bitmap_allocator.f
hw/rtl/ffba_pkg.sv
hw/rtl/ffba_in_if.sv
hw/rtl/ffba_out_if.sv
hw/rtl/ffba_map_ram.sv
hw/rtl/ffba_scan_unit.sv
hw/rtl/first_fit_bitmap_allocator.sv
sim/ffba_alloc_monitor.sv
sim/first_fit_bitmap_allocator_tb.sv
